>>> src/skd_pkg.sv
// skd_pkg: shared types and constants for the scan code key decoder.
// No dependencies; imported by the front, queue, back and top modules.
`default_nettype none

package skd_pkg;

  // Number of entries in the key table; higher indices decode to 0
  localparam int TABLE_ENTRIES = 86;

  // Release flag position in a raw scan byte
  localparam int RELEASE_BIT = 7;

  // Key codes of the two shift keys ('F' and 'G')
  localparam logic [6:0] LSHIFT_KEY = 7'h46;
  localparam logic [6:0] RSHIFT_KEY = 7'h47;

  // Event kinds reported on the result channel
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } ev_kind_t;

  // Classified item passed from the front to the back
  typedef struct packed {
    logic       is_break;
    logic [6:0] code;
  } key_item_t;

endpackage

`default_nettype wire

>>> src/scancode_key_decoder_unit.sv
// Set-1 scan code key decoder: one result per scan byte, one byte per cycle sustained while out_ready is held.
// Each item is registered in the front register, a queue slot and the result register before
// out_valid rises; the back stage reads and updates the key-down map for each item it takes,
// which sets the sustained rate.
// Reset (rst_n, synchronous, active low) clears the key-down map and empties all stages.
// Depends on skd_pkg, skd_front, skd_queue and skd_back.
`default_nettype none

module scancode_key_decoder_unit
  import skd_pkg::*;
#(
  parameter int FIFO_DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_scan_byte,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [1:0]        out_event_kind,
  output logic signed [7:0] out_signed_code,
  output logic [6:0]        out_key_code,
  output logic [6:0]        out_shifted_char,
  output logic              out_shift_held
);

  logic      f_valid;
  logic      f_ready;
  key_item_t f_item;
  logic      q_valid;
  logic      q_ready;
  key_item_t q_item;

  // Accept and classify scan bytes
  skd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_scan_byte (in_scan_byte),
    .item_valid   (f_valid),
    .item_ready   (f_ready),
    .item         (f_item)
  );

  // Decouple classification from map update
  skd_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Track held keys and produce results
  skd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (q_valid),
    .item_ready       (q_ready),
    .item             (q_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_signed_code  (out_signed_code),
    .out_key_code     (out_key_code),
    .out_shifted_char (out_shifted_char),
    .out_shift_held   (out_shift_held)
  );

endmodule

`default_nettype wire

>>> src/skd_front.sv
// skd_front: accepts raw scan bytes, looks up the key code, registers the item.
// Depends on skd_pkg.
`default_nettype none

module skd_front
  import skd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_scan_byte,
  output logic            item_valid,
  input  wire logic       item_ready,
  output key_item_t       item
);

  logic      valid_r;
  logic      valid_nxt;
  key_item_t item_r;
  key_item_t item_nxt;
  logic      take;

  // Set-1 key table lookup, zero past the populated entries
  function automatic logic [6:0] key_lookup(input logic [6:0] idx);
    logic [6:0] c;
    case (idx)
      7'd1:  c = 7'h41;  7'd2:  c = 7'h31;  7'd3:  c = 7'h32;  7'd4:  c = 7'h33;
      7'd5:  c = 7'h34;  7'd6:  c = 7'h35;  7'd7:  c = 7'h36;  7'd8:  c = 7'h37;
      7'd9:  c = 7'h38;  7'd10: c = 7'h39;  7'd11: c = 7'h30;  7'd12: c = 7'h2D;
      7'd13: c = 7'h3D;  7'd14: c = 7'h08;  7'd15: c = 7'h09;  7'd16: c = 7'h71;
      7'd17: c = 7'h77;  7'd18: c = 7'h65;  7'd19: c = 7'h72;  7'd20: c = 7'h74;
      7'd21: c = 7'h79;  7'd22: c = 7'h75;  7'd23: c = 7'h69;  7'd24: c = 7'h6F;
      7'd25: c = 7'h70;  7'd26: c = 7'h5B;  7'd27: c = 7'h5D;  7'd28: c = 7'h0A;
      7'd29: c = 7'h45;  7'd30: c = 7'h61;  7'd31: c = 7'h73;  7'd32: c = 7'h64;
      7'd33: c = 7'h66;  7'd34: c = 7'h67;  7'd35: c = 7'h68;  7'd36: c = 7'h6A;
      7'd37: c = 7'h6B;  7'd38: c = 7'h6C;  7'd39: c = 7'h3B;  7'd40: c = 7'h27;
      7'd41: c = 7'h60;  7'd42: c = 7'h46;  7'd43: c = 7'h5C;  7'd44: c = 7'h7A;
      7'd45: c = 7'h78;  7'd46: c = 7'h63;  7'd47: c = 7'h76;  7'd48: c = 7'h62;
      7'd49: c = 7'h6E;  7'd50: c = 7'h6D;  7'd51: c = 7'h2C;  7'd52: c = 7'h2E;
      7'd53: c = 7'h2F;  7'd54: c = 7'h47;  7'd55: c = 7'h2A;  7'd56: c = 7'h48;
      7'd57: c = 7'h20;  7'd58: c = 7'h4A;  7'd59: c = 7'h4B;  7'd60: c = 7'h4C;
      7'd61: c = 7'h4D;  7'd62: c = 7'h4E;  7'd63: c = 7'h4F;  7'd64: c = 7'h50;
      7'd65: c = 7'h51;  7'd66: c = 7'h52;  7'd67: c = 7'h54;  7'd68: c = 7'h55;
      7'd69: c = 7'h56;  7'd70: c = 7'h57;  7'd71: c = 7'h37;  7'd72: c = 7'h38;
      7'd73: c = 7'h39;  7'd74: c = 7'h2D;  7'd75: c = 7'h34;  7'd76: c = 7'h35;
      7'd77: c = 7'h36;  7'd78: c = 7'h2B;  7'd79: c = 7'h31;  7'd80: c = 7'h32;
      7'd81: c = 7'h33;  7'd82: c = 7'h30;  7'd83: c = 7'h2E;  7'd84: c = 7'h58;
      7'd85: c = 7'h59;
      default: c = 7'h00;
    endcase
    if ({1'b0, idx} >= 8'(TABLE_ENTRIES)) begin
      c = 7'h00;
    end
    return c;
  endfunction

  // Accept while the stage is empty or draining into the queue
  assign in_ready = !valid_r || item_ready;
  assign take     = in_valid && in_ready;

  // Classify the incoming byte
  always_comb begin
    item_nxt         = item_r;
    valid_nxt        = valid_r;
    if (take) begin
      item_nxt.is_break = in_scan_byte[RELEASE_BIT];
      item_nxt.code     = key_lookup(in_scan_byte[6:0]);
      valid_nxt         = 1'b1;
    end else if (item_ready) begin
      valid_nxt        = 1'b0;
    end
  end

  // Hold the classified item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

>>> src/skd_queue.sv
// skd_queue: short FIFO of classified key items between front and back.
// Depends on skd_pkg.
`default_nettype none

module skd_queue
  import skd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  key_item_t      push_item,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output key_item_t      pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  key_item_t      slots_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r;
  logic [PW-1:0]  rd_ptr_nxt;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;
  logic           push;
  logic           pop;

  // Advance a pointer with wrap at the depth
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots_r[rd_ptr_r];

  // Update pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> src/skd_back.sv
// skd_back: updates the key-down map, applies shift translation, holds the result.
// Depends on skd_pkg.
`default_nettype none

module skd_back
  import skd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  key_item_t        item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_event_kind,
  output logic signed [7:0] out_signed_code,
  output logic [6:0]       out_key_code,
  output logic [6:0]       out_shifted_char,
  output logic             out_shift_held
);

  logic [127:0] map_r;
  logic [127:0] map_nxt;
  logic         valid_r;
  logic         valid_nxt;
  ev_kind_t     kind_r;
  ev_kind_t     kind_nxt;
  logic [7:0]   scode_r;
  logic [7:0]   scode_nxt;
  logic [6:0]   code_r;
  logic [6:0]   shifted_r;
  logic [6:0]   shifted_nxt;
  logic         shift_r;
  logic         shift_nxt;
  logic         pop;
  logic         held;

  // US shift translation of a key code
  function automatic logic [6:0] shift_xlate(input logic [6:0] c);
    logic [6:0] r;
    case (c)
      7'h60: r = 7'h7E;  7'h31: r = 7'h21;  7'h32: r = 7'h40;  7'h33: r = 7'h23;
      7'h34: r = 7'h24;  7'h35: r = 7'h25;  7'h36: r = 7'h5E;  7'h37: r = 7'h26;
      7'h38: r = 7'h2A;  7'h39: r = 7'h28;  7'h30: r = 7'h29;  7'h2D: r = 7'h5F;
      7'h3D: r = 7'h2B;  7'h5B: r = 7'h7B;  7'h5D: r = 7'h7D;  7'h5C: r = 7'h7C;
      7'h3B: r = 7'h3A;  7'h27: r = 7'h22;  7'h2C: r = 7'h3C;  7'h2E: r = 7'h3E;
      7'h2F: r = 7'h3F;
      default: r = c;
    endcase
    if (c inside {[7'h61:7'h7A]}) begin
      r = c - 7'h20;
    end
    return r;
  endfunction

  // Take a new item when the result register is empty or being drained
  assign item_ready = !valid_r || out_ready;
  assign pop        = item_valid && item_ready;
  assign held       = map_r[item.code];

  // Resolve the event and the updated map
  always_comb begin
    map_nxt     = map_r;
    kind_nxt    = EV_NONE;
    scode_nxt   = 8'h00;
    if (item.is_break) begin
      if (held) begin
        map_nxt[item.code] = 1'b0;
        kind_nxt           = EV_RELEASE;
        scode_nxt          = 8'(9'h000 - {2'b00, item.code});
      end
    end else if (!held) begin
      map_nxt[item.code] = 1'b1;
      kind_nxt           = EV_PRESS;
      scode_nxt          = {1'b0, item.code};
    end
    shift_nxt   = map_nxt[LSHIFT_KEY] || map_nxt[RSHIFT_KEY];
    shifted_nxt = shift_nxt ? shift_xlate(item.code) : item.code;
    valid_nxt   = pop ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  end

  // Commit map and result on a transfer from the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      map_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (pop) begin
        map_r <= map_nxt;
      end
    end
    if (pop) begin
      kind_r    <= kind_nxt;
      scode_r   <= scode_nxt;
      code_r    <= item.code;
      shifted_r <= shifted_nxt;
      shift_r   <= shift_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_event_kind   = kind_r;
  assign out_signed_code  = scode_r;
  assign out_key_code     = code_r;
  assign out_shifted_char = shifted_r;
  assign out_shift_held   = shift_r;

  // A press reports the code itself
  a_press_code: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r == EV_PRESS) |-> (scode_r == {1'b0, code_r}))
    else $error("press result code mismatch");

  // A suppressed event reports zero
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r == EV_NONE) |-> (scode_r == 8'h00))
    else $error("suppressed event with nonzero code");

  // Shift flag tracks the map while a result is held
  a_shift_map: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (shift_r == (map_r[LSHIFT_KEY] || map_r[RSHIFT_KEY])))
    else $error("shift flag disagrees with key-down map");

  // An accepted press leaves its key held
  a_press_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && kind_nxt == EV_PRESS) |=> map_r[$past(item.code)])
    else $error("press did not set key-down bit");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Testbench for scancode_key_decoder_unit: set-1 scan bytes in, key events out.
// A directed table, then random key sequences, each result checked against its typed
// value or a local key-down map predictor. Depends on skd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module testbench;
  import skd_pkg::*;

  localparam int RANDOM_BYTES = 1800;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 400;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] scode;
    logic [6:0] key;
    logic [6:0] shifted;
    logic       held;
  } key_result_t;

  typedef struct packed {
    logic [7:0]  scan;
    bit          typed;
    key_result_t want;
  } scan_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_scan_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_event_kind;
  logic signed [7:0] out_signed_code;
  logic [6:0] out_key_code;
  logic [6:0] out_shifted_char;
  logic       out_shift_held;

  scancode_key_decoder_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_scan_byte     (in_scan_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_signed_code  (out_signed_code),
    .out_key_code     (out_key_code),
    .out_shifted_char (out_shifted_char),
    .out_shift_held   (out_shift_held)
  );

  // Key table: scan index to key code
  logic [6:0] key_rom [0:TABLE_ENTRIES-1] = '{
    7'h00, 7'h41, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h45,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h46, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h47, 7'h2A, 7'h48, 7'h20, 7'h4A, 7'h4B,
    7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h54, 7'h55, 7'h56,
    7'h57, 7'h37, 7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2E, 7'h58, 7'h59
  };

  // Directed stimulus; typed rows carry their result, the rest use the predictor
  scan_row_t directed_rows [25] = '{
    // unmatched release of code zero straight after reset
    '{8'h80, 1'b1, '{EV_NONE,    8'h00, 7'h00, 7'h00, 1'b0}},
    // press, repeat and release of code zero
    '{8'h00, 1'b1, '{EV_PRESS,   8'h00, 7'h00, 7'h00, 1'b0}},
    '{8'h00, 1'b1, '{EV_NONE,    8'h00, 7'h00, 7'h00, 1'b0}},
    '{8'h80, 1'b1, '{EV_RELEASE, 8'h00, 7'h00, 7'h00, 1'b0}},
    // indices past the table decode to code zero
    '{8'h7F, 1'b1, '{EV_PRESS,   8'h00, 7'h00, 7'h00, 1'b0}},
    '{8'h56, 1'b1, '{EV_NONE,    8'h00, 7'h00, 7'h00, 1'b0}},
    '{8'hFF, 1'b1, '{EV_RELEASE, 8'h00, 7'h00, 7'h00, 1'b0}},
    // last table entry, press and release
    '{8'h55, 1'b1, '{EV_PRESS,   8'h59, 7'h59, 7'h59, 1'b0}},
    '{8'hD5, 1'b1, '{EV_RELEASE, 8'hA7, 7'h59, 7'h59, 1'b0}},
    // shift handling on letters and punctuation
    '{8'h10, 1'b0, '0}, '{8'h2A, 1'b0, '0}, '{8'h10, 1'b0, '0},
    '{8'h29, 1'b0, '0}, '{8'h2B, 1'b0, '0}, '{8'h36, 1'b0, '0},
    '{8'hAA, 1'b0, '0}, '{8'h02, 1'b0, '0}, '{8'hB6, 1'b0, '0},
    '{8'h28, 1'b0, '0},
    // extended prefixes and host bytes decode as plain bytes
    '{8'hE0, 1'b0, '0}, '{8'hE1, 1'b0, '0}, '{8'hEE, 1'b0, '0},
    '{8'hF0, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'h1C, 1'b0, '0}
  };

  logic        key_held [128];
  key_result_t expected_events [$];
  logic [6:0]  held_scan_idx [$];
  bit          quiet_phase = 1'b0;
  int          error_count = 0;
  int          bytes_sent = 0;
  int          results_checked = 0;
  int          press_count = 0;
  int          release_count = 0;
  int          suppressed_count = 0;
  int          shifted_count = 0;
  int          cycle_count = 0;

  initial foreach (key_held[i]) key_held[i] = 1'b0;

  always #5 clk = ~clk;

  // US shift layer
  function automatic logic [6:0] shift_symbol(input logic [6:0] c);
    if (c >= 7'h61 && c <= 7'h7A) return c - 7'h20;
    case (c)
      7'h60: return 7'h7E;
      7'h31: return 7'h21;
      7'h32: return 7'h40;
      7'h33: return 7'h23;
      7'h34: return 7'h24;
      7'h35: return 7'h25;
      7'h36: return 7'h5E;
      7'h37: return 7'h26;
      7'h38: return 7'h2A;
      7'h39: return 7'h28;
      7'h30: return 7'h29;
      7'h2D: return 7'h5F;
      7'h3D: return 7'h2B;
      7'h5B: return 7'h7B;
      7'h5D: return 7'h7D;
      7'h5C: return 7'h7C;
      7'h3B: return 7'h3A;
      7'h27: return 7'h22;
      7'h2C: return 7'h3C;
      7'h2E: return 7'h3E;
      7'h2F: return 7'h3F;
      default: return c;
    endcase
  endfunction

  // Decode one byte and update the key-down map
  function automatic key_result_t predict_key_event(input logic [7:0] scan);
    key_result_t r;
    logic [6:0]  idx;
    logic [6:0]  code;
    idx = scan[6:0];
    code = (idx < TABLE_ENTRIES) ? key_rom[idx] : 7'd0;
    r.kind = EV_NONE;
    r.scode = 8'h00;
    if (scan[RELEASE_BIT]) begin
      if (key_held[code]) begin
        key_held[code] = 1'b0;
        r.kind = EV_RELEASE;
        r.scode = 8'h00 - {1'b0, code};
      end
    end else if (!key_held[code]) begin
      key_held[code] = 1'b1;
      r.kind = EV_PRESS;
      r.scode = {1'b0, code};
    end
    r.key = code;
    r.held = key_held[LSHIFT_KEY] | key_held[RSHIFT_KEY];
    r.shifted = r.held ? shift_symbol(code) : code;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
    end
  endtask

  // Offer one byte, hold it until the transfer, then record its expected result
  task automatic send_scan_byte(input logic [7:0] scan, input bit typed,
                                input key_result_t want);
    int          gap;
    key_result_t pred;
    gap = quiet_phase ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_scan_byte <= scan;
    do @(posedge clk); while (in_ready !== 1'b1);
    pred = predict_key_event(scan);
    expected_events.push_back(typed ? want : pred);
    bytes_sent++;
  endtask

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stalls, two long hold-offs, compare each transfer
  initial begin : result_side
    int          hold;
    key_result_t want;
    forever begin
      if (results_checked == 300 || results_checked == 1100)
        hold = LONG_HOLD;
      else
        hold = quiet_phase ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n === 1'b1 && out_valid === 1'b1));
      if (expected_events.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing expected, kind %h code %h", $time,
                 out_event_kind, out_signed_code);
      end else begin
        want = expected_events.pop_front();
        check_field("event_kind", {6'd0, want.kind}, {6'd0, out_event_kind});
        check_field("signed_code", want.scode, out_signed_code);
        check_field("key_code", {1'b0, want.key}, {1'b0, out_key_code});
        check_field("shifted_char", {1'b0, want.shifted}, {1'b0, out_shifted_char});
        check_field("shift_held", {7'd0, want.held}, {7'd0, out_shift_held});
        results_checked++;
        case (want.kind)
          EV_PRESS:   press_count++;
          EV_RELEASE: release_count++;
          default:    suppressed_count++;
        endcase
        if (want.held) shifted_count++;
      end
    end
  end

  // Input side: reset, directed table, random key sequences, drain
  initial begin : scan_side
    int          r;
    int          pos;
    logic [6:0]  pick;
    logic [7:0]  scan;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_scan_byte(directed_rows[i].scan, directed_rows[i].typed, directed_rows[i].want);

    for (int n = 0; n < RANDOM_BYTES; n++) begin
      // alternate stretches without idling on either side
      quiet_phase = ((n / 150) % 4) == 1;
      r = $urandom_range(0, 99);
      if (r < 15) begin
        scan = 8'($urandom_range(0, 255));
      end else if (r < 27) begin
        // shift keys, pressed or released
        pick = $urandom_range(0, 1) ? 7'd42 : 7'd54;
        scan = {1'($urandom_range(0, 1)), pick};
      end else if (r < 60 && held_scan_idx.size() > 0) begin
        // release a key held earlier
        pos = $urandom_range(0, held_scan_idx.size() - 1);
        scan = {1'b1, held_scan_idx[pos]};
        held_scan_idx.delete(pos);
      end else begin
        pick = (r >= 95) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 85));
        scan = {1'b0, pick};
        if (held_scan_idx.size() < 8) held_scan_idx.push_back(pick);
      end
      send_scan_byte(scan, 1'b0, '0);
    end
    quiet_phase = 1'b0;
    in_valid <= 1'b0;

    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    error_count += expected_events.size();

    $display("Sent %0d scan bytes (%0d directed), checked %0d results in %0d cycles.",
             bytes_sent, $size(directed_rows), results_checked, cycle_count);
    $display("Events: %0d presses, %0d releases, %0d suppressed, %0d with shift held.",
             press_count, release_count, suppressed_count, shifted_count);
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
